FILE: rtl/core/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

    localparam int DIST_W       = 11;
    localparam int LIMIT_W      = 11;
    localparam int TRIG_W       = 8;
    localparam int LISTEN_W     = 16;
    localparam int PHASE_W      = 17;
    localparam int CFG_DATA_W   = 16;
    localparam int OUT_CHANNELS = 3;
    localparam int CM_DIVISOR   = 58;

    localparam logic [DIST_W-1:0]   DIST_MAX            = 11'd2047;
    localparam logic [LIMIT_W-1:0]  NEAR_LIMIT_RESET    = 11'd100;
    localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RESET = 8'd10;
    localparam logic [LISTEN_W-1:0] LISTEN_TICKS_RESET  = 16'd30000;

    typedef enum logic [1:0] {
        CFG_NEAR_LIMIT    = 2'd0,
        CFG_TRIGGER_TICKS = 2'd1,
        CFG_LISTEN_TICKS  = 2'd2
    } cfg_index_t;

    // Per-tick control that every channel lane sees.
    typedef struct packed {
        logic advance;
        logic listen;
        logic last;
    } lane_ctl_t;

    // Tick information carried from the lane stage to the merge stage.
    typedef struct packed {
        logic valid;
        logic trig;
        logic refresh;
    } tick_t;

endpackage

FILE: rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration, cycle sequencer, lanes and merge.
// Each input beat is one microsecond tick carrying the echo pin levels. The block accepts a
// beat on every clock unless stalled and returns one result beat per input beat; a stall on
// the result side holds the input side only once both pipeline registers are full. The cycle
// sequencer counts ticks through a trigger phase of trigger_ticks and a listen phase of
// listen_ticks (zero counts as one), and every channel lane times its own echo pulse. On the
// last listen tick the merge stage turns the latched widths into centimetres by a reciprocal
// multiply with one correction step and sets the near flags; that result beat shows the new
// values with refreshed high. Configuration writes are taken at any time but should be made
// while the block is idle.
module ultrasonic_echo_ranger #(
    parameter int CHANNELS   = 3,
    parameter int COUNT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_echo_levels,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_trigger_level,
    output logic [2:0]                         m_near_flags,
    output logic [uer_pkg::DIST_W-1:0]         m_distance_first,
    output logic [uer_pkg::DIST_W-1:0]         m_distance_second,
    output logic [uer_pkg::DIST_W-1:0]         m_distance_third,
    output logic                               m_refreshed,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [uer_pkg::LIMIT_W-1:0]  near_limit_reg;
    logic [uer_pkg::TRIG_W-1:0]   trigger_ticks_reg;
    logic [uer_pkg::LISTEN_W-1:0] listen_ticks_reg;

    logic [uer_pkg::PHASE_W-1:0]  phase_reg;
    logic [uer_pkg::PHASE_W-1:0]  phase_next;
    logic [uer_pkg::PHASE_W:0]    listen_eff;
    logic [uer_pkg::PHASE_W:0]    total;
    logic                         trig_now;
    logic                         last_now;
    logic                         accept;

    uer_pkg::lane_ctl_t                  lane_ctl;
    logic [CHANNELS-1:0][COUNT_BITS-1:0] width_next;

    uer_pkg::tick_t                      s1_tick_reg;
    uer_pkg::tick_t                      s1_tick_next;
    logic [CHANNELS-1:0][COUNT_BITS-1:0] s1_width_reg;
    logic                                s1_take;

    logic [uer_pkg::OUT_CHANNELS-1:0][uer_pkg::DIST_W-1:0] distances;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_limit_reg    <= uer_pkg::NEAR_LIMIT_RESET;
            trigger_ticks_reg <= uer_pkg::TRIGGER_TICKS_RESET;
            listen_ticks_reg  <= uer_pkg::LISTEN_TICKS_RESET;
        end else if (cfg_valid) begin
            unique case (uer_pkg::cfg_index_t'(cfg_index))
                uer_pkg::CFG_NEAR_LIMIT:    near_limit_reg    <= cfg_data[uer_pkg::LIMIT_W-1:0];
                uer_pkg::CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::CFG_LISTEN_TICKS:  listen_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready    = !s1_tick_reg.valid || s1_take;
    assign accept     = s_valid && s_ready;
    assign listen_eff = (listen_ticks_reg == '0) ? (uer_pkg::PHASE_W+1)'(1)
                                                 : (uer_pkg::PHASE_W+1)'(listen_ticks_reg);
    assign total      = (uer_pkg::PHASE_W+1)'(trigger_ticks_reg) + listen_eff;
    assign trig_now   = phase_reg < uer_pkg::PHASE_W'(trigger_ticks_reg);
    assign last_now   = ((uer_pkg::PHASE_W+1)'(phase_reg) + 1'b1) >= total;
    assign phase_next = last_now ? '0 : phase_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    assign lane_ctl.advance = accept;
    assign lane_ctl.listen  = !trig_now;
    assign lane_ctl.last    = last_now;

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_lane
            logic echo_level;
            if (c < uer_pkg::OUT_CHANNELS) begin : g_pin
                assign echo_level = s_echo_levels[c];
            end else begin : g_quiet
                assign echo_level = 1'b0;
            end
            uer_lane #(
                .COUNT_BITS(COUNT_BITS)
            ) u_lane (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (lane_ctl),
                .echo_level(echo_level),
                .width_next(width_next[c])
            );
        end
    endgenerate

    always_comb begin
        s1_tick_next = s1_tick_reg;
        if (accept) begin
            s1_tick_next.valid   = 1'b1;
            s1_tick_next.trig    = trig_now;
            s1_tick_next.refresh = last_now;
        end else if (s1_take) begin
            s1_tick_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tick_reg <= '0;
        end else begin
            s1_tick_reg <= s1_tick_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_width_reg <= width_next;
        end
    end

    uer_merge #(
        .CHANNELS  (CHANNELS),
        .COUNT_BITS(COUNT_BITS)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .tick           (s1_tick_reg),
        .widths         (s1_width_reg),
        .near_limit     (near_limit_reg),
        .take           (s1_take),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_trigger_level(m_trigger_level),
        .m_near_flags   (m_near_flags),
        .m_distances    (distances),
        .m_refreshed    (m_refreshed)
    );

    assign m_distance_first  = distances[0];
    assign m_distance_second = distances[1];
    assign m_distance_third  = distances[2];

endmodule

FILE: rtl/core/uer_lane.sv
// Echo pulse timer for one channel: edge detection, pulse counter and latched width.
module uer_lane #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  uer_pkg::lane_ctl_t    ctl,
    input  logic                  echo_level,
    output logic [COUNT_BITS-1:0] width_next
);

    logic                  prev_reg;
    logic                  prev_next;
    logic                  counting_reg;
    logic                  counting_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;
    logic [COUNT_BITS-1:0] width_reg;

    assign count_inc = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg
                                                         : count_reg + 1'b1;

    always_comb begin
        prev_next     = prev_reg;
        counting_next = counting_reg;
        count_next    = count_reg;
        width_next    = width_reg;
        if (ctl.advance) begin
            prev_next = echo_level;
            if (ctl.listen) begin
                if (!counting_reg) begin
                    if (echo_level && !prev_reg) begin
                        counting_next = 1'b1;
                        count_next    = '0;
                    end
                end else begin
                    count_next = count_inc;
                    if (!echo_level && prev_reg) begin
                        width_next = count_inc;
                    end
                end
            end
            if (ctl.last) begin
                counting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= 1'b0;
            counting_reg <= 1'b0;
            count_reg    <= '0;
            width_reg    <= '0;
        end else begin
            prev_reg     <= prev_next;
            counting_reg <= counting_next;
            count_reg    <= count_next;
            width_reg    <= width_next;
        end
    end

endmodule

FILE: rtl/core/uer_cm_div.sv
// Conversion of an echo width in microseconds to centimetres, saturated to the field width.
module uer_cm_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic [COUNT_BITS-1:0]      width,
    output logic [uer_pkg::DIST_W-1:0] dist_cm
);

    localparam int SHIFT = COUNT_BITS + 6;
    localparam int MW    = COUNT_BITS + 1;
    localparam int PW    = COUNT_BITS + MW;
    localparam logic [MW-1:0] RECIP =
        MW'((64'd1 << SHIFT) / 64'(uer_pkg::CM_DIVISOR));
    localparam logic [COUNT_BITS:0] DIV_C = (COUNT_BITS+1)'(uer_pkg::CM_DIVISOR);

    logic [PW-1:0]         product;
    logic [COUNT_BITS:0]   q_est;
    logic [COUNT_BITS:0]   q_times;
    logic [COUNT_BITS:0]   rem;
    logic [COUNT_BITS:0]   q_fix;

    // The reciprocal estimate is low by at most one; one compare corrects it.
    assign product = PW'(width) * PW'(RECIP);
    assign q_est   = (COUNT_BITS+1)'(product[PW-1:SHIFT]);
    assign q_times = (q_est << 6) - (q_est << 2) - (q_est << 1);
    assign rem     = (COUNT_BITS+1)'(width) - q_times;
    assign q_fix   = (rem >= DIV_C) ? q_est + 1'b1 : q_est;

    assign dist_cm = (q_fix > (COUNT_BITS+1)'(uer_pkg::DIST_MAX))
                   ? uer_pkg::DIST_MAX
                   : q_fix[uer_pkg::DIST_W-1:0];

endmodule

FILE: rtl/core/uer_merge.sv
// Merge stage: converts the lane widths, forms the near flags and holds the result beat.
module uer_merge #(
    parameter int CHANNELS   = 3,
    parameter int COUNT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  uer_pkg::tick_t                      tick,
    input  logic [CHANNELS-1:0][COUNT_BITS-1:0] widths,
    input  logic [uer_pkg::LIMIT_W-1:0]         near_limit,
    output logic                                take,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic                                m_trigger_level,
    output logic [uer_pkg::OUT_CHANNELS-1:0]    m_near_flags,
    output logic [uer_pkg::OUT_CHANNELS-1:0][uer_pkg::DIST_W-1:0] m_distances,
    output logic                                m_refreshed
);

    logic [uer_pkg::OUT_CHANNELS-1:0][uer_pkg::DIST_W-1:0] dist_conv;
    logic [uer_pkg::OUT_CHANNELS-1:0]                      near_conv;

    logic                                                  valid_reg;
    logic                                                  trig_reg;
    logic                                                  refreshed_reg;
    logic [uer_pkg::OUT_CHANNELS-1:0]                      near_reg;
    logic [uer_pkg::OUT_CHANNELS-1:0][uer_pkg::DIST_W-1:0] dist_reg;

    genvar c;
    generate
        for (c = 0; c < uer_pkg::OUT_CHANNELS; c++) begin : g_out
            if (c < CHANNELS) begin : g_conv
                uer_cm_div #(
                    .COUNT_BITS(COUNT_BITS)
                ) u_div (
                    .width  (widths[c]),
                    .dist_cm(dist_conv[c])
                );
            end else begin : g_none
                assign dist_conv[c] = '0;
            end
            assign near_conv[c] = (dist_conv[c] != '0) && (dist_conv[c] < near_limit);
        end
    endgenerate

    assign take = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            trig_reg      <= 1'b0;
            refreshed_reg <= 1'b0;
            near_reg      <= '0;
            dist_reg      <= '0;
        end else if (tick.valid && take) begin
            valid_reg     <= 1'b1;
            trig_reg      <= tick.trig;
            refreshed_reg <= tick.refresh;
            if (tick.refresh) begin
                near_reg <= near_conv;
                dist_reg <= dist_conv;
            end
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_valid         = valid_reg;
    assign m_trigger_level = trig_reg;
    assign m_refreshed     = refreshed_reg;
    assign m_near_flags    = near_reg;
    assign m_distances     = dist_reg;

endmodule
